// File: rtl/ilcm_pkg.sv
// Shared constants, types and register codes for the input level calibration meter.
// No dependencies; every other file imports this package.
package ilcm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAG_W       = SAMPLE_BITS - 1;
  localparam int SQ_FBITS    = 2 * MAG_W;

  localparam int ENERGY_W = 48;
  localparam int HALF_W   = ENERGY_W / 2;
  localparam int COEFF_W  = 32;
  localparam int MUL_A_W  = COEFF_W + 1;
  localparam int PROD_W   = MUL_A_W + HALF_W;
  localparam int WIDE_W   = PROD_W + HALF_W;

  localparam logic [COEFF_W-1:0] PEAK_DECAY = 32'd4292819812;

  localparam int LOG_FRAC_W = 16;
  localparam int LOG_STEPS  = 16;
  localparam int LOG_CNT_W  = $clog2(LOG_STEPS);
  localparam int MANT_W     = 31;
  localparam int EXP_W      = $clog2(ENERGY_W + 1);
  localparam int NEG_L_W    = EXP_W + LOG_FRAC_W;

  localparam int DBK_W = 26;
  localparam logic [DBK_W-1:0] DB_K = 26'd50504453;
  localparam int DBP_W = NEG_L_W + 1 + DBK_W;
  localparam int Q_W   = DBP_W + 1 - 32;

  localparam int LEVEL_W  = 16;
  localparam int COMP_W   = 13;
  localparam int EXPL_W   = 15;
  localparam int DB_FLOOR = 30720;
  localparam int EXP_LOW  = -15360;
  localparam int COMP_LIM = 3072;
  localparam int OFF_LIM  = 768;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [COEFF_W-1:0]        COEFF_RESET    = 32'd4294743600;
  localparam logic signed [EXPL_W-1:0]  EXPECTED_RESET = EXPL_W'(-4608);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING = 2'd0,
    REG_EXPECTED  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [COEFF_W-1:0]       coeff;
    logic signed [EXPL_W-1:0] expected;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [MAG_W-1:0] mag;
  } mag_item_t;

endpackage

// File: rtl/ilcm_if.sv
// Handshake channels of the level meter: input samples, results, register writes.
// Depends on ilcm_pkg.
interface ilcm_in_if;
  import ilcm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          not_finite;
  modport source (output valid, sample, not_finite, input ready);
  modport sink (input valid, sample, not_finite, output ready);
endinterface

interface ilcm_out_if;
  import ilcm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [LEVEL_W-1:0]   rms_db;
  logic signed [LEVEL_W-1:0]   peak_db;
  logic signed [LEVEL_W-1:0]   mismatch_db;
  logic signed [COMP_W-1:0]    compensation_db;
  logic                        level_off;
  modport source (output valid, rms_db, peak_db, mismatch_db, compensation_db, level_off,
                  input ready);
  modport sink (input valid, rms_db, peak_db, mismatch_db, compensation_db, level_off,
                output ready);
endinterface

interface ilcm_cfg_if;
  import ilcm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/input_level_calibration_meter_core.sv
// Input level calibration meter, top level: register port, front end, back end.
// Depends on ilcm_pkg, ilcm_if, ilcm_front and ilcm_back.
//
// Each sample word yields one result word: smoothed RMS level, decaying peak level,
// mismatch against the expected level, a +-12 dB compensation and an off-level flag,
// all in 1/256 dB. In the back end a sample is fetched from the queue, passes the
// energy pole on the shared 33x24 multiplier, launches two log2 units that run their
// 16 squaring steps side by side, then gets dB scaling and mismatch and waits for the
// result register to be free; the log2 squaring loop is the longest step. A two-word
// queue lets the input side accept while the back end works or the output stalls.
// Register writes are taken at any time and should only be made while the block is idle.
module input_level_calibration_meter_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  ilcm_in_if.sink      in_i,
  ilcm_out_if.source   out_o,
  ilcm_cfg_if.sink     cfg_i
);
  import ilcm_pkg::*;

  cfg_t      cfg_q;
  mag_item_t item;
  logic      pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff    <= COEFF_RESET;
      cfg_q.expected <= EXPECTED_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SMOOTHING: cfg_q.coeff <= cfg_i.data[COEFF_W-1:0];
        REG_EXPECTED:  cfg_q.expected <= cfg_i.data[EXPL_W-1:0];
        default: ;
      endcase
    end
  end

  ilcm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .item_o (item)
  );

  ilcm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (item),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// File: rtl/ilcm_log2.sv
// Iterative log2 unit: leading-one search, normalize, 16 squaring steps.
// Result is -log2 in Q16. Depends on ilcm_pkg.
module ilcm_log2 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ilcm_pkg::ENERGY_W-1:0]    value_i,
  input  logic [ilcm_pkg::EXP_W-1:0]       fbits_i,
  output logic                             busy_o,
  output logic [ilcm_pkg::NEG_L_W-1:0]     neg_l_o
);
  import ilcm_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_FIND = 4'b0010,
    L_NORM = 4'b0100,
    L_SQR  = 4'b1000
  } log_state_e;

  log_state_e                      state_q, state_d;
  logic [LOG_CNT_W-1:0]            cnt_q;
  logic [ENERGY_W-1:0]             v_q;
  logic [EXP_W-1:0]                n_q, msb;
  logic [MANT_W-1:0]               m_q, m_sq;
  logic [LOG_FRAC_W-1:0]           frac_q, frac_d;
  logic [NEG_L_W-1:0]              neg_l_q;
  logic [ENERGY_W+MANT_W-2:0]      norm_wide;
  logic [2*MANT_W-1:0]             sqr;
  logic [MANT_W:0]                 sq_sh;
  logic                            last;

  always_comb begin
    msb = '0;
    for (int i = 0; i < ENERGY_W; i++) begin
      if (v_q[i]) msb = EXP_W'(i);
    end
  end

  assign norm_wide = {v_q, {(MANT_W-1){1'b0}}} >> n_q;
  assign sqr       = m_q * m_q;
  assign sq_sh     = sqr[2*MANT_W-1:MANT_W-1];
  assign m_sq      = sq_sh[MANT_W] ? sq_sh[MANT_W:1] : sq_sh[MANT_W-1:0];
  assign frac_d    = {frac_q[LOG_FRAC_W-2:0], sq_sh[MANT_W]};
  assign last      = (cnt_q == LOG_CNT_W'(LOG_STEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE: if (start_i) state_d = L_FIND;
      L_FIND: state_d = L_NORM;
      L_NORM: state_d = L_SQR;
      L_SQR:  if (last) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == L_NORM) cnt_q <= '0;
      else if (state_q == L_SQR) cnt_q <= cnt_q + LOG_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) v_q <= value_i;
    if (state_q == L_FIND) n_q <= msb;
    if (state_q == L_NORM) begin
      m_q    <= norm_wide[MANT_W-1:0];
      frac_q <= '0;
    end
    if (state_q == L_SQR) begin
      m_q    <= m_sq;
      frac_q <= frac_d;
      if (last) begin
        neg_l_q <= {fbits_i - n_q, {LOG_FRAC_W{1'b0}}} - NEG_L_W'(frac_d);
      end
    end
  end

  assign busy_o  = (state_q != L_IDLE);
  assign neg_l_o = neg_l_q;

endmodule

// File: rtl/ilcm_front.sv
// Front end: takes sample words, forms the saturated magnitude, queues it.
// Depends on ilcm_pkg and ilcm_if.
module ilcm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ilcm_in_if.sink               in_i,
  input  logic                  pop_i,
  output ilcm_pkg::mag_item_t   item_o
);
  import ilcm_pkg::*;

  logic [MAG_W-1:0]       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]      count_q;
  logic [SAMPLE_BITS-1:0] neg_val;
  logic [MAG_W-1:0]       mag;
  logic                   push, pop;

  assign neg_val = SAMPLE_BITS'(~in_i.sample) + SAMPLE_BITS'(1);

  always_comb begin
    if (in_i.not_finite) begin
      mag = '0;
    end else if (in_i.sample[SAMPLE_BITS-1]) begin
      // most negative code saturates to full scale
      mag = neg_val[SAMPLE_BITS-1] ? {MAG_W{1'b1}} : neg_val[MAG_W-1:0];
    end else begin
      mag = in_i.sample[MAG_W-1:0];
    end
  end

  assign in_i.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push && !pop) count_q <= count_q + QCNT_W'(1);
      else if (pop && !push) count_q <= count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= mag;
  end

  assign item_o.valid = (count_q != '0);
  assign item_o.mag   = mem_q[rd_ptr_q];

endmodule

// File: rtl/ilcm_back.sv
// Back end: energy and peak recurrences, two log2 units, dB scaling, result register.
// Depends on ilcm_pkg, ilcm_if and ilcm_log2.
module ilcm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ilcm_pkg::cfg_t        cfg_i,
  input  ilcm_pkg::mag_item_t   item_i,
  output logic                  pop_o,
  ilcm_out_if.source            out_o
);
  import ilcm_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE   = 7'b0000001,
    B_ENERGY = 7'b0000010,
    B_LOG    = 7'b0000100,
    B_WAIT   = 7'b0001000,
    B_DB1    = 7'b0010000,
    B_DB2    = 7'b0100000,
    B_FIN    = 7'b1000000
  } back_state_e;

  localparam logic [2:0] STEP_LAST = 3'd4;
  localparam logic [DBP_W:0] ROUND_HALF = {{(DBP_W-31){1'b0}}, 1'b1, 31'b0};

  back_state_e                 state_q, state_d;
  logic [2:0]                  step_q, step_d;
  logic                        log_start, out_load, busy_e, busy_p;

  logic [ENERGY_W-1:0]         energy_q, e_new_q, sh, sq48;
  logic [MAG_W-1:0]            peak_q, pk_q, mag_q;
  logic [2*MAG_W-1:0]          sq_q, sq_full;
  logic [SQ_FBITS+ENERGY_W-1:0] sq_wide;
  logic [MUL_A_W-1:0]          d_coeff, mul_a;
  logic [HALF_W-1:0]           mul_b;
  logic [PROD_W-1:0]           mul_res, prod_q, part_q;
  logic [WIDE_W-1:0]           wide;
  logic [MAG_W+COEFF_W-1:0]    pk_prod;

  logic [NEG_L_W-1:0]          neg_l_e, neg_l_p;
  logic [NEG_L_W+DBK_W-1:0]    dp_e;
  logic [DBP_W-1:0]            dp_p, dprod_e_q, dprod_p_q;
  logic signed [LEVEL_W-1:0]   rms_q, pdb_q, rms_d, pdb_d, exp_ext, exp_c;
  logic signed [LEVEL_W:0]     mis, comp_full;
  logic signed [COMP_W-1:0]    comp;
  logic                        off;

  logic                        out_valid_q;
  logic signed [LEVEL_W-1:0]   o_rms_q, o_pdb_q, o_mis_q;
  logic signed [COMP_W-1:0]    o_comp_q;
  logic                        o_off_q;

  function automatic logic signed [LEVEL_W-1:0] level_of(logic [DBP_W-1:0] p, logic zero);
    logic [DBP_W:0] sum;
    logic [Q_W-1:0] q;
    sum = {1'b0, p} + ROUND_HALF;
    q   = sum[DBP_W:32];
    if (zero || q > Q_W'(DB_FLOOR)) return LEVEL_W'(-DB_FLOOR);
    return -$signed(LEVEL_W'(q));
  endfunction

  // energy: two Q32 products, each as lo/hi 24-bit halves on one multiplier
  assign sq_full = item_i.mag * item_i.mag;
  assign sq_wide = {sq_q, {ENERGY_W{1'b0}}} >> SQ_FBITS;
  assign sq48    = sq_wide[ENERGY_W-1:0];
  assign d_coeff = {1'b1, {COEFF_W{1'b0}}} - {1'b0, cfg_i.coeff};
  assign mul_a   = (step_q < 3'd2) ? {1'b0, cfg_i.coeff} : d_coeff;

  always_comb begin
    case (step_q)
      3'd0:    mul_b = energy_q[HALF_W-1:0];
      3'd1:    mul_b = energy_q[ENERGY_W-1:HALF_W];
      3'd2:    mul_b = sq48[HALF_W-1:0];
      default: mul_b = sq48[ENERGY_W-1:HALF_W];
    endcase
  end

  assign mul_res = mul_a * mul_b;
  assign wide    = WIDE_W'(part_q) + {prod_q, {HALF_W{1'b0}}};
  assign sh      = wide[COEFF_W +: ENERGY_W];
  assign pk_prod = peak_q * PEAK_DECAY;

  ilcm_log2 u_log_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .value_i (energy_q),
    .fbits_i (EXP_W'(ENERGY_W)),
    .busy_o  (busy_e),
    .neg_l_o (neg_l_e)
  );

  ilcm_log2 u_log_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .value_i (ENERGY_W'(peak_q)),
    .fbits_i (EXP_W'(MAG_W)),
    .busy_o  (busy_p),
    .neg_l_o (neg_l_p)
  );

  assign dp_e  = neg_l_e * DB_K;
  assign dp_p  = {neg_l_p, 1'b0} * DB_K;
  assign rms_d = level_of(dprod_e_q, energy_q == '0);
  assign pdb_d = level_of(dprod_p_q, peak_q == '0);

  always_comb begin
    exp_ext = $signed({{(LEVEL_W-EXPL_W){cfg_i.expected[EXPL_W-1]}}, cfg_i.expected});
    if (exp_ext < EXP_LOW) exp_c = LEVEL_W'(EXP_LOW);
    else if (exp_ext > 0) exp_c = '0;
    else exp_c = exp_ext;
    mis       = $signed({rms_q[LEVEL_W-1], rms_q}) - $signed({exp_c[LEVEL_W-1], exp_c});
    comp_full = -mis;
    if (comp_full > COMP_LIM) comp = COMP_W'(COMP_LIM);
    else if (comp_full < -COMP_LIM) comp = COMP_W'(-COMP_LIM);
    else comp = COMP_W'(comp_full);
    off = (mis > OFF_LIM) || (mis < -OFF_LIM);
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    pop_o     = 1'b0;
    log_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      B_IDLE: if (item_i.valid) begin
        pop_o   = 1'b1;
        step_d  = '0;
        state_d = B_ENERGY;
      end
      B_ENERGY: begin
        step_d = step_q + 3'd1;
        if (step_q == STEP_LAST) state_d = B_LOG;
      end
      B_LOG: begin
        log_start = 1'b1;
        state_d   = B_WAIT;
      end
      B_WAIT: if (!busy_e && !busy_p) state_d = B_DB1;
      B_DB1: state_d = B_DB2;
      B_DB2: state_d = B_FIN;
      B_FIN: if (!out_valid_q || out_o.ready) begin
        out_load = 1'b1;
        state_d  = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      energy_q    <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == B_ENERGY && step_q == 3'd1) peak_q <= (pk_q > mag_q) ? pk_q : mag_q;
      if (state_q == B_ENERGY && step_q == STEP_LAST) energy_q <= e_new_q + sh;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mag_q <= item_i.mag;
      sq_q  <= sq_full;
    end
    if (state_q == B_ENERGY) begin
      if (step_q < STEP_LAST) prod_q <= mul_res;
      if (step_q == 3'd0) pk_q <= pk_prod[COEFF_W +: MAG_W];
      if (step_q == 3'd1 || step_q == 3'd3) part_q <= prod_q;
      if (step_q == 3'd2) e_new_q <= sh;
    end
    if (state_q == B_DB1) begin
      dprod_e_q <= DBP_W'(dp_e);
      dprod_p_q <= dp_p;
    end
    if (state_q == B_DB2) begin
      rms_q <= rms_d;
      pdb_q <= pdb_d;
    end
    if (out_load) begin
      o_rms_q  <= rms_q;
      o_pdb_q  <= pdb_q;
      o_mis_q  <= LEVEL_W'(mis);
      o_comp_q <= comp;
      o_off_q  <= off;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.rms_db          = o_rms_q;
  assign out_o.peak_db         = o_pdb_q;
  assign out_o.mismatch_db     = o_mis_q;
  assign out_o.compensation_db = o_comp_q;
  assign out_o.level_off       = o_off_q;

endmodule
